[design/vpt_pkg.sv]
package vpt_pkg;

    localparam int NUM_CHANNELS = 8;
    localparam int BASE_RATE_HZ = 1024;

    localparam int CH_W   = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int TICK_W = $clog2(BASE_RATE_HZ);
    localparam int LG_W   = 4;
    localparam int EVT_W  = 16;

    // Rates run from 2 Hz up to the base rate, all powers of two.
    localparam logic [LG_W-1:0]   MIN_RATE_LG    = LG_W'(1);
    localparam int                MAX_RATE_LG    = TICK_W;
    localparam logic [LG_W-1:0]   OPEN_RATE_LG   = LG_W'(1);
    localparam logic [TICK_W-1:0] TICK_LAST      = TICK_W'(BASE_RATE_HZ - 1);
    localparam logic [EVT_W-1:0]  EVENT_MAX      = '1;

    localparam logic [2:0] SIZE_NONE = 3'd0;
    localparam logic [2:0] SIZE_B1   = 3'd1;
    localparam logic [2:0] SIZE_B2   = 3'd2;
    localparam logic [2:0] SIZE_B4   = 3'd4;

    typedef enum logic [1:0] {
        ACT_TICK     = 2'd0,
        ACT_OPEN     = 2'd1,
        ACT_SET_RATE = 2'd2,
        ACT_ARM      = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_BAD_SIZE    = 2'd1,
        ST_BAD_RATE    = 2'd2,
        ST_BAD_CHANNEL = 2'd3
    } t_status;

    typedef struct packed {
        t_action     action;
        logic [2:0]  channel;
        logic [31:0] value;
        logic [2:0]  size_bytes;
    } t_req;

    typedef struct packed {
        t_status    status;
        logic [2:0] accepted_bytes;
        logic [7:0] released_mask;
    } t_rsp;

    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_CMD  = 2'd1,
        S_WALK = 2'd2,
        S_RESP = 2'd3
    } t_state;

    typedef struct packed {
        logic load;
        logic tick_inc;
        logic exec;
        logic walk;
    } t_dp_cmd;

    typedef struct packed {
        logic last_ch;
    } t_dp_stat;

endpackage

[design/vpt_ctrl.sv]
module vpt_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  vpt_pkg::t_action  i_action,
    input  vpt_pkg::t_dp_stat i_stat,
    output vpt_pkg::t_dp_cmd  o_cmd,
    output logic              o_busy,
    output logic              o_valid
);

    vpt_pkg::t_state r_state;
    vpt_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= vpt_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            vpt_pkg::S_IDLE: begin
                if (i_start) begin
                    n_state = (i_action == vpt_pkg::ACT_TICK) ? vpt_pkg::S_WALK
                                                              : vpt_pkg::S_CMD;
                end
            end
            vpt_pkg::S_CMD: begin
                n_state = vpt_pkg::S_RESP;
            end
            vpt_pkg::S_WALK: begin
                if (i_stat.last_ch) begin
                    n_state = vpt_pkg::S_RESP;
                end
            end
            vpt_pkg::S_RESP: begin
                n_state = vpt_pkg::S_IDLE;
            end
            default: begin
                n_state = vpt_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd   = '0;
        o_busy  = 1'b1;
        o_valid = 1'b0;
        case (r_state)
            vpt_pkg::S_IDLE: begin
                o_busy         = 1'b0;
                o_cmd.load     = i_start;
                o_cmd.tick_inc = i_start && (i_action == vpt_pkg::ACT_TICK);
            end
            vpt_pkg::S_CMD: begin
                o_cmd.exec = 1'b1;
            end
            vpt_pkg::S_WALK: begin
                o_cmd.walk = 1'b1;
            end
            vpt_pkg::S_RESP: begin
                o_valid = 1'b1;
            end
            default: begin
                o_busy = 1'b1;
            end
        endcase
    end

    a_accept_goes_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> o_busy)
        else $error("accepted request did not make the block busy");

    a_valid_then_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_busy && !o_valid)
        else $error("result strobe lasted more than one cycle");

    a_walk_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.walk && i_stat.last_ch) |=> o_valid)
        else $error("channel walk did not end in a result");

    a_load_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |-> !o_busy && !o_cmd.walk && !o_cmd.exec)
        else $error("request loaded while busy");

endmodule

[design/vpt_datapath.sv]
module vpt_datapath (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  vpt_pkg::t_req     i_req,
    input  vpt_pkg::t_dp_cmd  i_cmd,
    output vpt_pkg::t_dp_stat o_stat,
    output vpt_pkg::t_rsp     o_rsp
);

    logic [vpt_pkg::TICK_W-1:0] r_tick;
    logic [vpt_pkg::LG_W-1:0]   r_rate  [vpt_pkg::NUM_CHANNELS];
    logic [vpt_pkg::EVT_W-1:0]  r_event [vpt_pkg::NUM_CHANNELS];
    logic [vpt_pkg::NUM_CHANNELS-1:0] r_wait;
    logic [vpt_pkg::CH_W-1:0]   r_idx;
    vpt_pkg::t_req              r_req;
    vpt_pkg::t_rsp              r_rsp;

    // Walk decode for the channel under r_idx.
    logic [vpt_pkg::LG_W-1:0]   walk_lg;
    logic [vpt_pkg::TICK_W-1:0] walk_mask;
    logic                       walk_fire;

    // Set-rate decode for the loaded request.
    logic                       req_ch_ok;
    logic [31:0]                set_rate;
    logic                       size_ok;
    logic                       rate_ok;
    logic [vpt_pkg::LG_W-1:0]   set_lg;

    assign o_stat.last_ch = (r_idx == vpt_pkg::CH_W'(vpt_pkg::NUM_CHANNELS - 1));
    assign o_rsp          = r_rsp;

    // A channel at rate 2^lg fires when the low (TICK_W - lg) counter bits are zero.
    assign walk_lg   = r_rate[r_idx];
    assign walk_mask = vpt_pkg::TICK_LAST >> walk_lg;
    assign walk_fire = (walk_lg != '0) && ((r_tick & walk_mask) == '0);

    assign req_ch_ok = (32'(r_req.channel) < 32'(vpt_pkg::NUM_CHANNELS));

    always_comb begin
        set_rate = '0;
        size_ok  = 1'b1;
        case (r_req.size_bytes)
            vpt_pkg::SIZE_B1: set_rate = {24'd0, r_req.value[7:0]};
            vpt_pkg::SIZE_B2: set_rate = {16'd0, r_req.value[15:0]};
            vpt_pkg::SIZE_B4: set_rate = r_req.value;
            default:          size_ok  = 1'b0;
        endcase
    end

    always_comb begin
        set_lg  = '0;
        rate_ok = (set_rate != '0) && ((set_rate & (set_rate - 32'd1)) == '0) &&
                  !set_rate[0] && (set_rate[31:vpt_pkg::MAX_RATE_LG+1] == '0);
        for (int i = 1; i <= vpt_pkg::MAX_RATE_LG; i++) begin
            if (set_rate[i]) begin
                set_lg = set_lg | vpt_pkg::LG_W'(i);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick <= '0;
            r_wait <= '0;
            r_idx  <= '0;
            for (int c = 0; c < vpt_pkg::NUM_CHANNELS; c++) begin
                r_rate[c]  <= '0;
                r_event[c] <= '0;
            end
        end else begin
            if (i_cmd.load) begin
                r_idx <= '0;
            end
            if (i_cmd.tick_inc) begin
                r_tick <= (r_tick == vpt_pkg::TICK_LAST) ? '0
                                                        : r_tick + vpt_pkg::TICK_W'(1);
            end
            if (i_cmd.exec && req_ch_ok) begin
                case (r_req.action)
                    vpt_pkg::ACT_OPEN: begin
                        r_rate[r_req.channel] <= vpt_pkg::OPEN_RATE_LG;
                    end
                    vpt_pkg::ACT_ARM: begin
                        r_wait[r_req.channel]  <= 1'b1;
                        r_event[r_req.channel] <= '0;
                    end
                    vpt_pkg::ACT_SET_RATE: begin
                        if (size_ok && rate_ok) begin
                            r_rate[r_req.channel] <= set_lg;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            if (i_cmd.walk) begin
                r_idx <= r_idx + vpt_pkg::CH_W'(1);
                if (walk_fire) begin
                    if (r_wait[r_idx]) begin
                        r_wait[r_idx]  <= 1'b0;
                        r_event[r_idx] <= '0;
                    end else if (r_event[r_idx] != vpt_pkg::EVENT_MAX) begin
                        r_event[r_idx] <= r_event[r_idx] + vpt_pkg::EVT_W'(1);
                    end
                end
            end
        end
    end

    // Request and result registers hold payload only.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req <= i_req;
            r_rsp <= '0;
        end
        if (i_cmd.exec) begin
            if (!req_ch_ok) begin
                r_rsp.status <= vpt_pkg::ST_BAD_CHANNEL;
            end else if (r_req.action == vpt_pkg::ACT_SET_RATE &&
                         r_req.size_bytes != vpt_pkg::SIZE_NONE) begin
                if (!size_ok) begin
                    r_rsp.status <= vpt_pkg::ST_BAD_SIZE;
                end else if (!rate_ok) begin
                    r_rsp.status <= vpt_pkg::ST_BAD_RATE;
                end else begin
                    r_rsp.accepted_bytes <= r_req.size_bytes;
                end
            end
        end
        if (i_cmd.walk && walk_fire && r_wait[r_idx] && (32'(r_idx) < 32'd8)) begin
            r_rsp.released_mask[r_idx[2:0]] <= 1'b1;
        end
    end

endmodule

[design/virtual_periodic_timer_channels.sv]
// Virtual periodic timer channels: a 1024 Hz base tick is divided into eight
// channels at power-of-two rates from 2 to 1024 Hz. Raise start with a request
// while busy is low; exactly one result follows on o_rsp, marked by a
// single-cycle o_valid strobe that cannot be held off, so it must be captured
// on that cycle. A tick request goes from accept to result through a load step,
// a walk of the channel registers one channel at a time through a single update
// unit, and a result step; open, set-rate and arm requests go through load,
// execute and result steps. busy stays high until the result strobe has gone.
module virtual_periodic_timer_channels (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    input  vpt_pkg::t_req i_req,
    output logic          busy,
    output logic          o_valid,
    output vpt_pkg::t_rsp o_rsp
);

    vpt_pkg::t_dp_cmd  dp_cmd;
    vpt_pkg::t_dp_stat dp_stat;

    vpt_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_action (i_req.action),
        .i_stat   (dp_stat),
        .o_cmd    (dp_cmd),
        .o_busy   (busy),
        .o_valid  (o_valid)
    );

    vpt_datapath u_datapath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .i_cmd   (dp_cmd),
        .o_stat  (dp_stat),
        .o_rsp   (o_rsp)
    );

endmodule
